// File: src/subscription_match_table_core_defines.svh
// assertion macros for the subscription match table
`ifndef SUBSCRIPTION_MATCH_TABLE_CORE_DEFINES_SVH
`define SUBSCRIPTION_MATCH_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on the rising clock edge
`define SMT_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smt assertion failed");
// next-cycle implication
`define SMT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smt assertion failed");
`else
`define SMT_ASSERT_IMPLIES(label, ante, cons)
`define SMT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: src/smt_pkg.sv
package smt_pkg;

   localparam int SUB_PORT_W = 8;
   localparam logic [4:0] MAX_RESULTS = 5'd16;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_LOOKUP = 2'd2
   } smt_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_NO_SPACE = 2'd2
   } smt_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } smt_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic exec_item;
      logic capture_match;
      logic emit_match;
   } smt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_lookup;
      logic scan_last;
   } smt_stat_type;

endpackage

// File: src/smt_ctrl.sv
module smt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output smt_pkg::smt_cmd_type cmd,
   input  smt_pkg::smt_stat_type stat
);

   smt_pkg::smt_state_type state_ff;
   smt_pkg::smt_state_type state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smt_pkg::ST_IDLE: begin
            if (req_valid) state_in = smt_pkg::ST_EXEC;
         end
         smt_pkg::ST_EXEC: begin
            if (stat.is_lookup) state_in = smt_pkg::ST_SCAN;
            else if (out_free) state_in = smt_pkg::ST_IDLE;
         end
         smt_pkg::ST_SCAN: begin
            if (out_free && stat.scan_last) state_in = smt_pkg::ST_IDLE;
         end
         default: state_in = smt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         smt_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         smt_pkg::ST_EXEC: begin
            cmd.capture_match = stat.is_lookup;
            cmd.exec_item     = !stat.is_lookup && out_free;
         end
         smt_pkg::ST_SCAN: begin
            cmd.emit_match = out_free;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.exec_item || cmd.emit_match;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/smt_datapath.sv
module smt_datapath #(
   parameter int SLOT_COUNT = 16,
   parameter int SUB_W      = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smt_pkg::smt_cmd_type  cmd,
   output smt_pkg::smt_stat_type stat,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_subscriber_id,
   input  logic [31:0]           req_message_id,
   input  logic [4:0]            req_lookup_limit,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_found_subscriber,
   output logic                  rsp_has_subscriber,
   output logic [4:0]            rsp_match_count,
   output logic                  rsp_last
);

   // latched item
   logic [1:0]       item_kind_ff;
   logic [SUB_W-1:0] item_sub_ff;
   logic [31:0]      item_msg_ff;
   logic [4:0]       item_limit_ff;
   logic [4:0]       limit_sat;

   // slot cells
   logic [SLOT_COUNT-1:0] used_ff;
   logic [SLOT_COUNT-1:0] used_in;
   logic [SUB_W-1:0]      slot_sub_ff [SLOT_COUNT];
   logic [31:0]           slot_msg_ff [SLOT_COUNT];

   logic [SLOT_COUNT-1:0] msg_eq;
   logic [SLOT_COUNT-1:0] sub_eq;
   logic [SLOT_COUNT-1:0] hit_vec;
   logic [SLOT_COUNT-1:0] free_vec;
   logic [SLOT_COUNT-1:0] free_oh;
   logic                  sub_null;
   logic                  do_add;
   logic                  do_remove;
   smt_pkg::smt_status_type exec_status;

   // lookup scan
   logic [SLOT_COUNT-1:0] scan_vec_ff;
   logic [SLOT_COUNT-1:0] scan_vec_in;
   logic [4:0]            count_ff;
   logic [4:0]            count_in;
   logic [4:0]            count_next;
   logic [SLOT_COUNT-1:0] pick_oh;
   logic [SLOT_COUNT-1:0] rest_vec;
   logic [SUB_W-1:0]      pick_sub;
   logic [7:0]            pick_sub_ext;
   logic                  scan_empty;
   logic                  scan_last;

   // result register
   logic [1:0] rsp_status_ff;
   logic [7:0] rsp_found_ff;
   logic       rsp_has_ff;
   logic [4:0] rsp_count_ff;
   logic       rsp_last_ff;

   assign limit_sat = (req_lookup_limit > smt_pkg::MAX_RESULTS) ? smt_pkg::MAX_RESULTS
                                                                : req_lookup_limit;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_kind_ff  <= req_kind;
         item_sub_ff   <= req_subscriber_id[SUB_W-1:0];
         item_msg_ff   <= req_message_id;
         item_limit_ff <= limit_sat;
      end
   end

   // per-slot comparators
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         msg_eq[i] = slot_msg_ff[i] == item_msg_ff;
         sub_eq[i] = slot_sub_ff[i] == item_sub_ff;
      end
   end

   assign hit_vec  = used_ff & msg_eq;
   assign free_vec = ~used_ff;
   assign free_oh  = free_vec & (~free_vec + SLOT_COUNT'(1));
   assign sub_null = item_sub_ff == '0;

   always_comb begin
      exec_status = smt_pkg::STATUS_OK;
      do_add      = 1'b0;
      do_remove   = 1'b0;
      case (item_kind_ff)
         smt_pkg::KIND_ADD: begin
            if (sub_null) exec_status = smt_pkg::STATUS_INVALID;
            else if (free_vec == '0) exec_status = smt_pkg::STATUS_NO_SPACE;
            else do_add = cmd.exec_item;
         end
         smt_pkg::KIND_REMOVE: begin
            do_remove = cmd.exec_item && !sub_null;
         end
         smt_pkg::KIND_LOOKUP: exec_status = smt_pkg::STATUS_OK;
         default: exec_status = smt_pkg::STATUS_INVALID;
      endcase
   end

   always_comb begin
      used_in = used_ff;
      if (do_add) used_in = used_ff | free_oh;
      if (do_remove) used_in = used_ff & ~(hit_vec & sub_eq);
   end

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else used_ff <= used_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (do_add && free_oh[i]) begin
            slot_sub_ff[i] <= item_sub_ff;
            slot_msg_ff[i] <= item_msg_ff;
         end
      end
   end

   // lowest remaining match
   assign pick_oh  = scan_vec_ff & (~scan_vec_ff + SLOT_COUNT'(1));
   assign rest_vec = scan_vec_ff & ~pick_oh;

   always_comb begin
      pick_sub = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (pick_oh[i]) pick_sub = pick_sub | slot_sub_ff[i];
      end
      pick_sub_ext              = '0;
      pick_sub_ext[SUB_W-1:0]   = pick_sub;
   end

   assign count_next = count_ff + 5'd1;
   assign scan_empty = (scan_vec_ff == '0) || (item_limit_ff == '0);
   assign scan_last  = scan_empty || (rest_vec == '0) || (count_next == item_limit_ff);

   always_comb begin
      scan_vec_in = scan_vec_ff;
      count_in    = count_ff;
      if (cmd.capture_match) begin
         scan_vec_in = hit_vec;
         count_in    = '0;
      end else if (cmd.emit_match) begin
         scan_vec_in = rest_vec;
         count_in    = count_next;
      end
   end

   always_ff @(posedge clock) begin
      scan_vec_ff <= scan_vec_in;
      count_ff    <= count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_item) begin
         rsp_status_ff <= exec_status;
         rsp_found_ff  <= '0;
         rsp_has_ff    <= 1'b0;
         rsp_count_ff  <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.emit_match) begin
         rsp_status_ff <= smt_pkg::STATUS_OK;
         rsp_found_ff  <= scan_empty ? '0 : pick_sub_ext;
         rsp_has_ff    <= !scan_empty;
         rsp_count_ff  <= scan_empty ? '0 : count_next;
         rsp_last_ff   <= scan_last;
      end
   end

   assign stat.is_lookup = item_kind_ff == smt_pkg::KIND_LOOKUP;
   assign stat.scan_last = scan_last;

   assign rsp_status           = rsp_status_ff;
   assign rsp_found_subscriber = rsp_found_ff;
   assign rsp_has_subscriber   = rsp_has_ff;
   assign rsp_match_count      = rsp_count_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

// File: src/subscription_match_table_core.sv
// add, remove and invalid kinds: accept latches the item, the exec state loads the result
// beat once the output is free; lookup: a beat per match (one empty beat if none), one beat
// per cycle while rsp_ready stays high; the scan register yields the lowest remaining match;
// one item is in flight at a time; the result register frees the input side once loaded
// reset is synchronous, active high: all slots become free at once, no clearing pass
`include "subscription_match_table_core_defines.svh"

module subscription_match_table_core #(
   parameter int SLOT_COUNT      = 16,
   parameter int SUBSCRIBER_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_subscriber_id,
   input  logic [31:0] req_message_id,
   input  logic [4:0]  req_lookup_limit,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_found_subscriber,
   output logic        rsp_has_subscriber,
   output logic [4:0]  rsp_match_count,
   output logic        rsp_last
);

   // stored subscriber width: ids wider than the port cannot arrive
   localparam int SUB_W = (SUBSCRIBER_BITS < smt_pkg::SUB_PORT_W) ? SUBSCRIBER_BITS
                                                                  : smt_pkg::SUB_PORT_W;

   smt_pkg::smt_cmd_type  cmd;
   smt_pkg::smt_stat_type stat;

   // sequencer: idle -> exec -> (scan) -> idle
   smt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // slot table, parallel compare, scan register and result register
   smt_datapath #(
      .SLOT_COUNT (SLOT_COUNT),
      .SUB_W      (SUB_W)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_kind             (req_kind),
      .req_subscriber_id    (req_subscriber_id),
      .req_message_id       (req_message_id),
      .req_lookup_limit     (req_lookup_limit),
      .rsp_status           (rsp_status),
      .rsp_found_subscriber (rsp_found_subscriber),
      .rsp_has_subscriber   (rsp_has_subscriber),
      .rsp_match_count      (rsp_match_count),
      .rsp_last             (rsp_last)
   );

   // a non-final beat taken is followed by the next beat of its lookup
   `SMT_ASSERT_NEXT(a_lookup_continues, rsp_valid && rsp_ready && !rsp_last, rsp_valid)
   // an accepted request is worked on before another is taken
   `SMT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
   // a match beat always carries a nonzero count
   `SMT_ASSERT_IMPLIES(a_match_counted, rsp_valid && rsp_has_subscriber, rsp_match_count != 5'd0)
   // a beat without a match ends its item
   `SMT_ASSERT_IMPLIES(a_empty_is_last, rsp_valid && !rsp_has_subscriber, rsp_last)

endmodule
